// ===== rtl/hmd_pkg.sv =====
// ----------------------------------------------------------------------------
// hmd_pkg: shared definitions for the hidden message deframer
// Result kind codes, header byte offsets and the result record that travels
// from the frame parser to the output stage.
// ----------------------------------------------------------------------------
package hmd_pkg;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_NAME   = 2'd1,
		KIND_OPTION = 2'd2,
		KIND_DATA   = 2'd3
	} result_kind_t;

	// Header layout, big-endian: check word, name length, region length,
	// option length.
	localparam logic [3:0] HDR_NAME_POS   = 4'd4;
	localparam logic [3:0] HDR_REGION_POS = 4'd5;
	localparam logic [3:0] HDR_OPTION_POS = 4'd9;
	localparam logic [3:0] HDR_LAST_POS   = 4'd12;

	typedef struct packed {
		result_kind_t kind;
		logic [7:0]   payload_byte;
		logic [31:0]  segment_index;
		logic [31:0]  check_word;
		logic [7:0]   name_length;
		logic [31:0]  region_length;
		logic [31:0]  option_length;
		logic         frame_last;
	} result_t;

endpackage

// ===== rtl/hidden_message_deframer.sv =====
// ----------------------------------------------------------------------------
// hidden_message_deframer: byte-stream frame parser
// Splits a byte stream into header, name, option and data results.
// ----------------------------------------------------------------------------
// The block takes one stream byte per cycle and can accept a new byte in
// every cycle, including while a finished result waits for the downstream
// side, as long as that result is taken in the same cycle. Each byte passes
// through the parse logic in the cycle it is accepted and its result, if
// any, appears on the output in the next cycle from the result register, so
// the sustained rate is one transaction per clock while results are taken.
// A frame begins at a byte flagged by frame_start and opens with a
// 13-byte big-endian header (check word, name length, region length, option
// length); header bytes give no result until the last one, which gives the
// header result. Every following name, option or data byte gives one result,
// with the header fields repeated on each, and the last byte of the frame is
// marked by frame_last. Bytes outside a frame are accepted and dropped, and
// frame_start restarts parsing at any time, abandoning a frame in progress.
// The check word is only reported, never verified.
// ----------------------------------------------------------------------------
module hidden_message_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  stream_byte,
	input  logic        frame_start,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  result_kind,
	output logic [7:0]  payload_byte,
	output logic [31:0] segment_index,
	output logic [31:0] check_word,
	output logic [7:0]  name_length,
	output logic [31:0] region_length,
	output logic [31:0] option_length,
	output logic        frame_last
);

	// The parser state advances on every accepted transaction; only the
	// bytes that produce a result load the result register.
	logic             accept;
	logic             res_valid;
	hmd_pkg::result_t res;
	hmd_pkg::result_t out_res;

	assign accept = in_valid && in_ready;

	hmd_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.stream_byte (stream_byte),
		.frame_start (frame_start),
		.res_valid   (res_valid),
		.res         (res)
	);

	hmd_out_stage u_out_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.res_valid (res_valid),
		.res       (res),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	// Unpack the registered result onto the output ports.
	assign result_kind   = out_res.kind;
	assign payload_byte  = out_res.payload_byte;
	assign segment_index = out_res.segment_index;
	assign check_word    = out_res.check_word;
	assign name_length   = out_res.name_length;
	assign region_length = out_res.region_length;
	assign option_length = out_res.option_length;
	assign frame_last    = out_res.frame_last;

	// A header result carries no byte and no position.
	a_header_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_kind == hmd_pkg::KIND_HEADER)
		|-> (payload_byte == 8'd0) && (segment_index == 32'd0))
		else $error("header result with nonzero payload or index");

	// An option byte always lies inside the declared option segment.
	a_option_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_kind == hmd_pkg::KIND_OPTION)
		|-> (segment_index < option_length) && (segment_index < region_length))
		else $error("option index outside option segment");

	// A data byte's index stays inside the region.
	a_data_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_kind == hmd_pkg::KIND_DATA)
		|-> segment_index < region_length)
		else $error("data index outside region");

	// A name byte ends the frame only as the last name byte of a frame
	// without region.
	a_name_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_kind == hmd_pkg::KIND_NAME) && frame_last
		|-> (region_length == 32'd0)
		&& (segment_index == ({24'd0, name_length} - 32'd1)))
		else $error("name byte ends frame at wrong place");

endmodule

// ===== rtl/hmd_parser.sv =====
// ----------------------------------------------------------------------------
// hmd_parser: frame parse state and per-byte classification
// Holds the parse phase, byte counter and header fields, and forms the result
// for each accepted byte in the same cycle.
// ----------------------------------------------------------------------------
module hmd_parser (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic [7:0]      stream_byte,
	input  logic            frame_start,
	output logic            res_valid,
	output hmd_pkg::result_t res
);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_HEADER,
		PH_NAME,
		PH_REGION
	} phase_t;

	phase_t      phase_q, phase_d, phase_eff;
	logic [31:0] count_q, count_d, count_eff;
	logic [31:0] check_q, check_d;
	logic [7:0]  name_len_q, name_len_d;
	logic [31:0] region_len_q, region_len_d;
	logic [31:0] option_len_q, option_len_d;
	logic [3:0]  hdr_pos;
	logic        name_end;
	logic        region_last;
	logic        is_option;

	always_comb begin
		phase_eff    = frame_start ? PH_HEADER : phase_q;
		count_eff    = frame_start ? 32'd0 : count_q;
		check_d      = frame_start ? 32'd0 : check_q;
		name_len_d   = frame_start ? 8'd0 : name_len_q;
		region_len_d = frame_start ? 32'd0 : region_len_q;
		option_len_d = frame_start ? 32'd0 : option_len_q;
		phase_d      = phase_eff;
		count_d      = count_eff;
		hdr_pos      = count_eff[3:0];
		name_end     = ({1'b0, count_eff} + 33'd1) >= {25'd0, name_len_q};
		region_last  = count_eff == (region_len_q - 32'd1);
		is_option    = count_eff < option_len_q;

		res_valid         = 1'b0;
		res.kind          = hmd_pkg::KIND_HEADER;
		res.payload_byte  = 8'd0;
		res.segment_index = 32'd0;
		res.frame_last    = 1'b0;

		unique case (phase_eff)
			PH_HEADER: begin
				if (hdr_pos < hmd_pkg::HDR_NAME_POS) begin
					check_d = {check_d[23:0], stream_byte};
				end else if (hdr_pos == hmd_pkg::HDR_NAME_POS) begin
					name_len_d = stream_byte;
				end else if (hdr_pos < hmd_pkg::HDR_OPTION_POS) begin
					region_len_d = {region_len_d[23:0], stream_byte};
				end else begin
					option_len_d = {option_len_d[23:0], stream_byte};
				end
				count_d = count_eff + 32'd1;
				if (hdr_pos == hmd_pkg::HDR_LAST_POS) begin
					count_d   = 32'd0;
					res_valid = 1'b1;
					if (name_len_d != 8'd0) begin
						phase_d = PH_NAME;
					end else if (region_len_d != 32'd0) begin
						phase_d = PH_REGION;
					end else begin
						phase_d        = PH_IDLE;
						res.frame_last = 1'b1;
					end
				end
			end
			PH_NAME: begin
				res_valid         = 1'b1;
				res.kind          = hmd_pkg::KIND_NAME;
				res.payload_byte  = stream_byte;
				res.segment_index = count_eff;
				res.frame_last    = name_end && (region_len_q == 32'd0);
				if (name_end) begin
					count_d = 32'd0;
					phase_d = (region_len_q == 32'd0) ? PH_IDLE : PH_REGION;
				end else begin
					count_d = count_eff + 32'd1;
				end
			end
			PH_REGION: begin
				res_valid         = 1'b1;
				res.payload_byte  = stream_byte;
				res.frame_last    = region_last;
				// Option length beyond the region makes every byte an option.
				if (is_option) begin
					res.kind          = hmd_pkg::KIND_OPTION;
					res.segment_index = count_eff;
				end else begin
					res.kind          = hmd_pkg::KIND_DATA;
					res.segment_index = count_eff - option_len_q;
				end
				if (region_last) begin
					phase_d = PH_IDLE;
					count_d = 32'd0;
				end else begin
					count_d = count_eff + 32'd1;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase

		res.check_word    = check_d;
		res.name_length   = name_len_d;
		res.region_length = region_len_d;
		res.option_length = option_len_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			count_q      <= 32'd0;
			check_q      <= 32'd0;
			name_len_q   <= 8'd0;
			region_len_q <= 32'd0;
			option_len_q <= 32'd0;
		end else if (accept) begin
			phase_q      <= phase_d;
			count_q      <= count_d;
			check_q      <= check_d;
			name_len_q   <= name_len_d;
			region_len_q <= region_len_d;
			option_len_q <= option_len_d;
		end
	end

endmodule

// ===== rtl/hmd_out_stage.sv =====
// ----------------------------------------------------------------------------
// hmd_out_stage: result register
// Holds one result until the downstream side takes it and tells the input
// side when a new byte may enter.
// ----------------------------------------------------------------------------
module hmd_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             res_valid,
	input  hmd_pkg::result_t res,
	output logic             out_valid,
	input  logic             out_ready,
	output hmd_pkg::result_t out_res
);

	logic             valid_q;
	hmd_pkg::result_t data_q;
	logic             accept;

	assign in_ready  = !valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = valid_q;
	assign out_res   = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (accept && res_valid) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && res_valid) begin
			data_q <= res;
		end
	end

endmodule

// ===== sim/tb_hidden_message_deframer.sv =====
// ----------------------------------------------------------------------------
// tb_hidden_message_deframer: self-checking testbench for the frame parser
// A queue of stream bytes feeds a valid/ready driver with random idle bursts.
// A monitor predicts each result when a byte transaction is accepted, then
// compares every accepted result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module tb_hidden_message_deframer;

	// Number of random bytes to generate after the directed opening.
	localparam int RANDOM_ITEMS   = 1300;
	// With this many bytes left to send, both sides stop idling.
	localparam int CALM_ITEMS     = 150;
	// The long receiver hold-off starts after this many accepted bytes.
	localparam int HOLDOFF_AFTER  = 400;
	localparam int HOLDOFF_CYCLES = 300;
	// Cycles to wait after the last result.
	localparam int DRAIN_CYCLES   = 10;
	localparam int HDR_BYTES      = 13;

	// Phases of the predicted frame parser.
	typedef enum logic [1:0] {
		PARSE_IDLE,
		PARSE_HEADER,
		PARSE_NAME,
		PARSE_REGION
	} parse_phase_t;

	// One byte transaction as the driver offers it.
	typedef struct packed {
		logic [7:0] data;
		logic       start;
	} stream_item_t;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic        in_ready;
	logic [7:0]  stream_byte = 8'd0;
	logic        frame_start = 1'b0;
	logic        out_valid;
	logic        out_ready   = 1'b0;
	logic [1:0]  result_kind;
	logic [7:0]  payload_byte;
	logic [31:0] segment_index;
	logic [31:0] check_word;
	logic [7:0]  name_length;
	logic [31:0] region_length;
	logic [31:0] option_length;
	logic        frame_last;

	hidden_message_deframer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.stream_byte   (stream_byte),
		.frame_start   (frame_start),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.result_kind   (result_kind),
		.payload_byte  (payload_byte),
		.segment_index (segment_index),
		.check_word    (check_word),
		.name_length   (name_length),
		.region_length (region_length),
		.option_length (option_length),
		.frame_last    (frame_last)
	);

	always #1 clk = ~clk;

	// Bytes waiting to be sent, and results predicted but not yet seen.
	stream_item_t     stream_q[$];
	hmd_pkg::result_t results_due[$];
	int               stream_total = 0;
	int               bytes_taken  = 0;
	int               mismatches   = 0;

	// Predicted parser state. Reset is applied only once, at the start of the
	// run, so the declaration values stand for the reset state.
	parse_phase_t parse_ph   = PARSE_IDLE;
	logic [31:0]  parse_cnt  = 32'd0;
	logic [31:0]  hold_check = 32'd0;
	logic [7:0]   hold_nlen  = 8'd0;
	logic [31:0]  hold_rlen  = 32'd0;
	logic [31:0]  hold_olen  = 32'd0;

	logic       holdoff_on   = 1'b0;
	logic       holdoff_done = 1'b0;
	int         holdoff_cnt  = 0;
	int         send_gap     = 0;
	int         recv_gap     = 0;

	// ------------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------------

	// Every result repeats the header fields of the frame it belongs to.
	function automatic hmd_pkg::result_t make_result(input hmd_pkg::result_kind_t kind,
			input logic [7:0] b, input logic [31:0] idx, input logic last);
		hmd_pkg::result_t r;
		r.kind          = kind;
		r.payload_byte  = b;
		r.segment_index = idx;
		r.check_word    = hold_check;
		r.name_length   = hold_nlen;
		r.region_length = hold_rlen;
		r.option_length = hold_olen;
		r.frame_last    = last;
		return r;
	endfunction

	// Advances the predicted parser by one accepted byte. fires tells whether
	// the byte produces a result.
	task automatic frame_parse(input logic [7:0] b, input logic start,
			output bit fires, output hmd_pkg::result_t r);
		logic [31:0] idx;
		bit          name_end;
		bit          last;
		fires = 1'b0;
		r     = '0;
		// A flagged byte restarts the header at any phase; a frame in
		// progress is dropped without a closing result.
		if (start) begin
			parse_ph   = PARSE_HEADER;
			parse_cnt  = 32'd0;
			hold_check = 32'd0;
			hold_nlen  = 8'd0;
			hold_rlen  = 32'd0;
			hold_olen  = 32'd0;
		end
		idx = parse_cnt;
		case (parse_ph)
			PARSE_HEADER: begin
				if (idx < hmd_pkg::HDR_NAME_POS)
					hold_check = {hold_check[23:0], b};
				else if (idx == hmd_pkg::HDR_NAME_POS)
					hold_nlen = b;
				else if (idx < hmd_pkg::HDR_OPTION_POS)
					hold_rlen = {hold_rlen[23:0], b};
				else
					hold_olen = {hold_olen[23:0], b};
				if (idx == hmd_pkg::HDR_LAST_POS) begin
					parse_cnt = 32'd0;
					if (hold_nlen != 8'd0)
						parse_ph = PARSE_NAME;
					else if (hold_rlen != 32'd0)
						parse_ph = PARSE_REGION;
					else
						parse_ph = PARSE_IDLE;
					// An empty frame ends on its own header result.
					fires = 1'b1;
					r = make_result(hmd_pkg::KIND_HEADER, 8'd0, 32'd0,
						parse_ph == PARSE_IDLE);
				end else begin
					parse_cnt = idx + 32'd1;
				end
			end
			PARSE_NAME: begin
				name_end  = (idx + 32'd1) >= {24'd0, hold_nlen};
				// With an empty region the last name byte closes the frame.
				last      = name_end && (hold_rlen == 32'd0);
				parse_cnt = name_end ? 32'd0 : idx + 32'd1;
				if (name_end)
					parse_ph = last ? PARSE_IDLE : PARSE_REGION;
				fires = 1'b1;
				r = make_result(hmd_pkg::KIND_NAME, b, idx, last);
			end
			PARSE_REGION: begin
				last = (idx == hold_rlen - 32'd1);
				// When the option length covers the whole region, no data
				// bytes appear at all.
				if (idx < hold_olen)
					r = make_result(hmd_pkg::KIND_OPTION, b, idx, last);
				else
					r = make_result(hmd_pkg::KIND_DATA, b, idx - hold_olen, last);
				fires = 1'b1;
				if (last) begin
					parse_ph  = PARSE_IDLE;
					parse_cnt = 32'd0;
				end else begin
					parse_cnt = idx + 32'd1;
				end
			end
			default: begin
				// Junk outside a frame is dropped.
				parse_ph = PARSE_IDLE;
			end
		endcase
	endtask

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------

	task automatic push_byte(input logic [7:0] b, input logic start);
		stream_item_t it;
		it.data  = b;
		it.start = start;
		stream_q.push_back(it);
	endtask

	// Queues a frame. Only the first hdr_keep header bytes are sent, and the
	// body is sent only after a full header; body_keep bytes follow then.
	// A short count leaves the frame to be cut off by the next start flag.
	task automatic push_frame(input logic [31:0] check, input logic [7:0] nlen,
			input logic [31:0] rlen, input logic [31:0] olen,
			input int hdr_keep, input int body_keep);
		logic [103:0] hdr;
		hdr = {check, nlen, rlen, olen};
		for (int j = 0; j < hdr_keep; j++)
			push_byte(hdr[103 - 8 * j -: 8], j == 0);
		if (hdr_keep == HDR_BYTES)
			for (int j = 0; j < body_keep; j++)
				push_byte(8'($urandom), 1'b0);
	endtask

	initial begin : stimulus
		int          pick;
		logic [7:0]  nlen;
		logic [31:0] rlen;
		logic [31:0] olen;

		// Directed opening: junk at both byte extremes, a header cut short by
		// a restart, and an empty frame with its check word and option length at
		// their maximum, so the option length lies far beyond the region.
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b0);
		push_frame(32'h0000_0000, 8'd0, 32'd0, 32'd0, 3, 0);
		push_frame(32'hFFFF_FFFF, 8'd0, 32'd0, 32'hFFFF_FFFF, HDR_BYTES, 0);

		// Random part. Most frames are well formed with random content so the
		// name and region phases are reached; the rest are cut off at random
		// points with random 32-bit lengths, and junk falls between frames.
		stream_total = stream_q.size() + RANDOM_ITEMS;
		while (stream_q.size() < stream_total) begin
			repeat ($urandom_range(0, 2))
				push_byte(8'($urandom), 1'b0);
			if ($urandom_range(0, 19) < 3) begin
				push_frame($urandom, 8'($urandom), $urandom, $urandom,
					$urandom_range(1, HDR_BYTES), $urandom_range(0, 20));
			end else begin
				pick = $urandom_range(0, 9);
				if (pick < 2)
					nlen = 8'd0;
				else if (pick < 9)
					nlen = 8'($urandom_range(1, 6));
				else
					nlen = 8'($urandom_range(7, 30));
				pick = $urandom_range(0, 9);
				if (pick < 2)
					rlen = 32'd0;
				else if (pick < 9)
					rlen = $urandom_range(1, 12);
				else
					rlen = $urandom_range(13, 40);
				case ($urandom_range(0, 5))
					0: olen = 32'd0;
					1: olen = rlen + $urandom_range(1, 3);
					2: olen = $urandom;
					3: olen = rlen;
					default: olen = $urandom_range(0, rlen);
				endcase
				push_frame($urandom, nlen, rlen, olen, HDR_BYTES, nlen + rlen);
			end
		end
		stream_total = stream_q.size();

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait for the last byte to be taken and every result to arrive.
		do @(negedge clk); while (stream_q.size() != 0 || in_valid);
		do @(negedge clk); while (results_due.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatches == 0 && results_due.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin : watchdog
		#400000;
		$display("tb: failure");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Driver: offers the queued bytes, holding each until its transaction is
	// accepted, with random idle bursts between transactions.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : driver
		stream_item_t it;
		if (!arst_n) begin
			in_valid    <= 1'b0;
			stream_byte <= 8'd0;
			frame_start <= 1'b0;
			send_gap    <= 0;
		end else if (!in_valid || in_ready) begin
			if (send_gap != 0) begin
				in_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (stream_q.size() != 0) begin
				it = stream_q.pop_front();
				in_valid    <= 1'b1;
				stream_byte <= it.data;
				frame_start <= it.start;
				if (stream_q.size() > CALM_ITEMS && $urandom_range(0, 7) == 0)
					send_gap <= $urandom_range(1, 10);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Long hold-off: once, the receiver stops taking results for a long
	// stretch while the sender keeps offering, so the result register fills
	// and the block has to stall its input.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holdoff_on   <= 1'b0;
			holdoff_done <= 1'b0;
			holdoff_cnt  <= 0;
		end else if (holdoff_on) begin
			if (holdoff_cnt == HOLDOFF_CYCLES - 1) begin
				holdoff_on   <= 1'b0;
				holdoff_done <= 1'b1;
			end
			holdoff_cnt <= holdoff_cnt + 1;
		end else if (!holdoff_done && bytes_taken >= HOLDOFF_AFTER) begin
			holdoff_on <= 1'b1;
		end
	end

	// Receiver: ready with random stall bursts that do not follow out_valid,
	// so stalls land on every phase of the parser.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_gap  <= 0;
		end else if (holdoff_on) begin
			out_ready <= 1'b0;
		end else if (recv_gap != 0) begin
			out_ready <= 1'b0;
			recv_gap  <= recv_gap - 1;
		end else begin
			out_ready <= 1'b1;
			if (bytes_taken + CALM_ITEMS < stream_total && $urandom_range(0, 7) == 0)
				recv_gap <= $urandom_range(1, 10);
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: checks an accepted result first, then predicts from an accepted
	// byte. Doing both in one process keeps the order fixed when a result and
	// a byte are taken at the same edge.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		hmd_pkg::result_t got;
		hmd_pkg::result_t want;
		bit               fires;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got.kind          = hmd_pkg::result_kind_t'(result_kind);
				got.payload_byte  = payload_byte;
				got.segment_index = segment_index;
				got.check_word    = check_word;
				got.name_length   = name_length;
				got.region_length = region_length;
				got.option_length = option_length;
				got.frame_last    = frame_last;
				if (results_due.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result: kind %0d byte %02h index %0d last %0b",
							result_kind, payload_byte, segment_index, frame_last);
					mismatches++;
				end else begin
					want = results_due.pop_front();
					if (got !== want) begin
						if (mismatches < 10) begin
							$display("result mismatch (expected / actual):");
							$display("  kind   %0d / %0d", want.kind, result_kind);
							$display("  byte   %02h / %02h", want.payload_byte, payload_byte);
							$display("  index  %0d / %0d", want.segment_index, segment_index);
							$display("  check  %08h / %08h", want.check_word, check_word);
							$display("  name   %0d / %0d", want.name_length, name_length);
							$display("  region %0d / %0d", want.region_length, region_length);
							$display("  option %0d / %0d", want.option_length, option_length);
							$display("  last   %0b / %0b", want.frame_last, frame_last);
						end
						mismatches++;
					end
				end
			end
			if (in_valid && in_ready) begin
				frame_parse(stream_byte, frame_start, fires, want);
				if (fires)
					results_due.push_back(want);
				bytes_taken <= bytes_taken + 1;
			end
		end
	end

endmodule

// ===== filelist.f =====
rtl/hmd_pkg.sv
rtl/hmd_parser.sv
rtl/hmd_out_stage.sv
rtl/hidden_message_deframer.sv
sim/tb_hidden_message_deframer.sv
